// ----- hdl/rkx_pkg.sv -----
// ----------------------------------------------------------------------------
// rkx_pkg
// Shared types and constants of the rotating-key XOR cipher.
// ----------------------------------------------------------------------------
package rkx_pkg;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic REG_KEY_LENGTH = 1'b0;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       kind;
        logic       wr_en;
        logic [5:0] addr_a;
        logic [5:0] addr_b;
        logic [2:0] off;
        logic [7:0] data;
        logic       last;
    } t_op;

endpackage

// ----- hdl/rkx_front.sv -----
// ----------------------------------------------------------------------------
// rkx_front
// Accepts items, tracks block position and rotation, emits key-store ops.
// ----------------------------------------------------------------------------
module rkx_front #(
    parameter int KEY_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_kind,
    input  logic [5:0]    i_key_index,
    input  logic [7:0]    i_data_byte,
    input  logic [6:0]    i_key_length,
    input  logic          i_len_wr,
    input  logic          i_q_full,
    output logic          o_push,
    output rkx_pkg::t_op  o_op
);

    localparam logic [6:0] CAP = 7'((KEY_BYTES < 64) ? KEY_BYTES : 64);

    logic [5:0] r_pos, n_pos;
    logic [8:0] r_rot, n_rot;
    logic [8:0] r_rmod, n_rmod;
    logic [2:0] r_red_cnt, n_red_cnt;
    logic [5:0] r_red_rem, n_red_rem;

    logic [6:0] len;
    logic [6:0] lm1;
    logic [9:0] nbits;
    logic       last;
    logic [5:0] pos;
    logic [9:0] sum;
    logic [9:0] start;
    logic [5:0] q;
    logic [5:0] q2;
    logic [9:0] rot_inc;
    logic [6:0] red_sh;
    logic       accept;

    always_comb begin
        if (i_key_length == 7'd0) begin
            len = 7'd1;
        end else if (i_key_length > CAP) begin
            len = CAP;
        end else begin
            len = i_key_length;
        end
    end

    assign lm1     = len - 7'd1;
    assign nbits   = {len, 3'b000};
    assign last    = ({1'b0, r_pos} >= lm1);
    assign pos     = last ? lm1[5:0] : r_pos;
    assign sum     = {1'b0, pos, 3'b000} + {1'b0, r_rmod};
    assign start   = (sum >= nbits) ? (sum - nbits) : sum;
    assign q       = start[8:3];
    assign q2      = ({1'b0, q} + 7'd1 == len) ? 6'd0 : (q + 6'd1);
    assign rot_inc = {1'b0, r_rmod} + 10'd1;

    assign o_ready = (r_red_cnt == 3'd0) && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        o_op.kind   = i_kind;
        o_op.wr_en  = ({3'b000, i_key_index} < 9'(KEY_BYTES));
        o_op.addr_a = (i_kind == rkx_pkg::KIND_DATA) ? q : i_key_index;
        o_op.addr_b = q2;
        o_op.off    = start[2:0];
        o_op.data   = i_data_byte;
        o_op.last   = last;
    end

    assign red_sh = {r_red_rem, r_rot[4'd2 + {1'b0, r_red_cnt}]};

    always_comb begin
        n_pos     = r_pos;
        n_rot     = r_rot;
        n_rmod    = r_rmod;
        n_red_cnt = r_red_cnt;
        n_red_rem = r_red_rem;
        if (i_len_wr) begin
            n_red_cnt = 3'd6;
            n_red_rem = 6'd0;
        end else if (r_red_cnt != 3'd0) begin
            n_red_rem = (red_sh >= len) ? 6'(red_sh - len) : red_sh[5:0];
            n_red_cnt = r_red_cnt - 3'd1;
            if (r_red_cnt == 3'd1) begin
                n_rmod = {n_red_rem, r_rot[2:0]};
            end
        end else if (accept) begin
            if (i_kind == rkx_pkg::KIND_KEY) begin
                n_pos  = 6'd0;
                n_rot  = 9'd0;
                n_rmod = 9'd0;
            end else if (last) begin
                n_pos  = 6'd0;
                n_rot  = (rot_inc >= nbits) ? 9'd0 : rot_inc[8:0];
                n_rmod = n_rot;
            end else begin
                n_pos = pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 6'd0;
            r_rot     <= 9'd0;
            r_rmod    <= 9'd0;
            r_red_cnt <= 3'd0;
            r_red_rem <= 6'd0;
        end else begin
            r_pos     <= n_pos;
            r_rot     <= n_rot;
            r_rmod    <= n_rmod;
            r_red_cnt <= n_red_cnt;
            r_red_rem <= n_red_rem;
        end
    end

endmodule

// ----- hdl/rkx_queue.sv -----
// ----------------------------------------------------------------------------
// rkx_queue
// Short FIFO of ops between the front and back parts.
// ----------------------------------------------------------------------------
module rkx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rkx_pkg::t_op  i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output rkx_pkg::t_op  o_rdata,
    output logic          o_empty
);

    localparam int AW = $clog2(rkx_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rkx_pkg::QUEUE_DEPTH + 1);

    rkx_pkg::t_op r_mem [rkx_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(rkx_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? AW'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_pop ? AW'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/rkx_back.sv -----
// ----------------------------------------------------------------------------
// rkx_back
// Key store, key byte extraction and output register.
// ----------------------------------------------------------------------------
module rkx_back #(
    parameter int KEY_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  rkx_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_cipher_byte,
    output logic          o_block_end
);

    localparam int AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [7:0] r_key [KEY_BYTES];

    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;
    logic [2:0] r_s1_off;
    logic [7:0] r_s1_data;
    logic       r_s1_last;
    logic       r_s1_valid, n_s1_valid;
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_cipher;
    logic       r_o_end;

    logic        out_free;
    logic        s1_move;
    logic [15:0] pair;
    logic [7:0]  kb;
    logic        pop_data;

    assign out_free = !r_o_valid || i_ready;
    assign s1_move  = r_s1_valid && out_free;
    assign o_pop    = !i_q_empty && (!r_s1_valid || out_free);
    assign pop_data = o_pop && (i_op.kind == rkx_pkg::KIND_DATA);

    assign pair = {r_rd_a, r_rd_b} << r_s1_off;
    assign kb   = pair[15:8];

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_op.kind == rkx_pkg::KIND_KEY) && i_op.wr_en) begin
            r_key[AW'(i_op.addr_a)] <= i_op.data;
        end
        if (pop_data) begin
            r_rd_a    <= r_key[AW'(i_op.addr_a)];
            r_rd_b    <= r_key[AW'(i_op.addr_b)];
            r_s1_off  <= i_op.off;
            r_s1_data <= i_op.data;
            r_s1_last <= i_op.last;
        end
        if (s1_move) begin
            r_o_cipher <= r_s1_data ^ kb;
            r_o_end    <= r_s1_last;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_o_valid  = r_o_valid;
        if (o_pop) begin
            n_s1_valid = pop_data;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        if (s1_move) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_cipher_byte = r_o_cipher;
    assign o_block_end   = r_o_end;

endmodule

// ----- hdl/rotating_key_xor_cipher.sv -----
// ----------------------------------------------------------------------------
// rotating_key_xor_cipher
// Byte stream XOR cipher with a key rotated by one bit per block.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): kind 0 writes key byte i_key_index and
// restarts the block position; kind 1 enciphers i_data_byte. Output channel
// (o_valid/i_ready) carries one cipher byte and a block-end flag per kind-1
// item; kind-0 items give nothing. key_length is set over the APB port at
// byte address 0 and may change only while the block is idle.
// Throughput: one item per cycle while o_ready is high. A result passes through
// the queue, the registered key-store read and the output register.
// After a key_length write the block reduces the rotation count to the new
// key bit count, one quotient bit a cycle, and o_ready stays low meanwhile.
// Reset: key_length is 1, position and rotation are 0, queue and output are
// empty; key bytes hold no value until written.
// When the receiver stalls, the output register holds, the key-store stage and
// the four-entry queue fill, and then o_ready drops.
// ----------------------------------------------------------------------------
module rotating_key_xor_cipher #(
    parameter int KEY_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [5:0]  i_key_index,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_cipher_byte,
    output logic        o_block_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]   r_key_length;
    logic         len_wr;
    logic         q_full;
    logic         q_empty;
    logic         push;
    logic         pop;
    rkx_pkg::t_op op_in;
    rkx_pkg::t_op op_out;

    assign pready = 1'b1;
    assign len_wr = psel && penable && pwrite && (paddr[2] == rkx_pkg::REG_KEY_LENGTH);
    assign prdata = (paddr[2] == rkx_pkg::REG_KEY_LENGTH) ? {25'd0, r_key_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 7'd1;
        end else if (len_wr) begin
            r_key_length <= pwdata[6:0];
        end
    end

    rkx_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_key_index  (i_key_index),
        .i_data_byte  (i_data_byte),
        .i_key_length (r_key_length),
        .i_len_wr     (len_wr),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_op         (op_in)
    );

    rkx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (op_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_rdata (op_out),
        .o_empty (q_empty)
    );

    rkx_back #(
        .KEY_BYTES (KEY_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_op          (op_out),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cipher_byte (o_cipher_byte),
        .o_block_end   (o_block_end)
    );

endmodule

// ----- dv/rotating_key_xor_cipher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotating_key_xor_cipher_tb
// Self-checking bench for the rotating-key XOR cipher. It loads the whole
// key, then runs directed bytes and random phases under many key lengths,
// with random gaps on both channels. A scoreboard class predicts each cipher
// byte and block-end flag and checks the output stream in order.
// ----------------------------------------------------------------------------
module rotating_key_xor_cipher_tb;

    localparam int CLK_HALF   = 6;
    localparam int CYCLE_CAP  = 300000;
    localparam int IDLE_PCT   = 31;
    localparam int KEY_SLOTS  = 64;

    typedef struct packed {
        logic [7:0] cipher;
        logic       block_end;
    } t_cipher_out;

    class cipher_board;
        logic [7:0]  key_mem [KEY_SLOTS];
        logic [5:0]  blk_pos;
        logic [8:0]  rot_count;
        logic [6:0]  key_len;
        t_cipher_out pending [$];
        int errors;
        int key_writes;
        int data_bytes;
        int block_ends;

        function new();
            blk_pos    = '0;
            rot_count  = '0;
            key_len    = 7'd1;
            errors     = 0;
            key_writes = 0;
            data_bytes = 0;
            block_ends = 0;
        endfunction

        function void set_key_length(logic [6:0] v);
            key_len = v;
        endfunction

        function void note_item(logic kind, logic [5:0] idx, logic [7:0] data);
            int          len;
            int          nbits;
            int          rot;
            int          p;
            int          start;
            int          q;
            int          off;
            int          nxt;
            logic [15:0] pair;
            logic [7:0]  kb;
            t_cipher_out res;
            if (kind == rkx_pkg::KIND_KEY) begin
                key_mem[idx] = data;
                blk_pos      = '0;
                rot_count    = '0;
                key_writes++;
                return;
            end
            len = key_len;
            if (len == 0) len = 1;
            if (len > KEY_SLOTS) len = KEY_SLOTS;
            nbits = len * 8;
            rot   = rot_count % nbits;
            p     = blk_pos;
            res.block_end = (p >= len - 1);
            if (res.block_end) p = len - 1;
            start = (p * 8 + rot) % nbits;
            q     = start >> 3;
            off   = start & 7;
            pair  = {key_mem[q], key_mem[(q + 1) % len]};
            pair  = pair << off;
            kb    = (off == 0) ? key_mem[q] : pair[15:8];
            res.cipher = data ^ kb;
            if (res.block_end) begin
                blk_pos = '0;
                nxt     = rot + 1;
                if (nxt >= nbits) nxt = 0;
                rot_count = nxt[8:0];
            end else begin
                blk_pos = p[5:0] + 6'd1;
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [7:0] cipher, logic block_end);
            t_cipher_out exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item cipher_byte %h block_end %b",
                         $time, cipher, block_end);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            data_bytes++;
            if (exp_res.block_end) block_ends++;
            if (cipher !== exp_res.cipher) begin
                $display("%0t: cipher_byte expected %h actual %h",
                         $time, exp_res.cipher, cipher);
                errors++;
            end
            if (block_end !== exp_res.block_end) begin
                $display("%0t: block_end expected %b actual %b",
                         $time, exp_res.block_end, block_end);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_kind      = 1'b0;
    logic [5:0]  i_key_index = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_ready     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_cipher_byte;
    logic        o_block_end;
    logic [31:0] prdata;
    logic        pready;

    cipher_board board = new();
    bit          steady = 1'b0;
    int          cycle_count = 0;
    int          len_settings = 0;

    rotating_key_xor_cipher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_key_index  (i_key_index),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cipher_byte(o_cipher_byte),
        .o_block_end  (o_block_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("rotating_key_xor_cipher_tb: errors");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready)
                board.check_result(o_cipher_byte, o_block_end);
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(logic kind, logic [5:0] idx, logic [7:0] data);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_key_index <= idx;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(kind, idx, data);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_length(logic [6:0] v);
        logic [31:0] noise;
        noise   = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * rkx_pkg::REG_KEY_LENGTH);
        pwdata  <= {noise[31:7], v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_key_length(v);
        len_settings++;
    endtask

    task automatic run_phase(logic [6:0] len, int n, int key_pct, bit hold_mid);
        wait_drained();
        write_key_length(len);
        for (int i = 0; i < n; i++) begin
            if (hold_mid && i == n / 2)
                wait_drained();
            if ($urandom_range(0, 99) < key_pct)
                send_item(rkx_pkg::KIND_KEY, 6'($urandom_range(0, 63)), 8'($urandom));
            else
                send_item(rkx_pkg::KIND_DATA, 6'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [6:0] lengths [12];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < KEY_SLOTS; k++)
            send_item(rkx_pkg::KIND_KEY, 6'(k), (k == 0) ? 8'h00 :
                      (k == KEY_SLOTS - 1) ? 8'hFF : 8'($urandom));

        // walk one full rotation of a one-byte key
        send_item(rkx_pkg::KIND_DATA, 6'h3F, 8'h00);
        send_item(rkx_pkg::KIND_DATA, 6'h00, 8'hFF);
        send_item(rkx_pkg::KIND_KEY, 6'h00, 8'h80);
        for (int k = 0; k < 10; k++)
            send_item(rkx_pkg::KIND_DATA, 6'($urandom), (k % 2) ? 8'hFF : 8'h00);

        wait_drained();
        write_key_length(7'd0);
        send_item(rkx_pkg::KIND_DATA, 6'h00, 8'hA5);
        send_item(rkx_pkg::KIND_DATA, 6'h00, 8'h5A);
        wait_drained();
        write_key_length(7'd64);
        for (int k = 0; k < 5; k++)
            send_item(rkx_pkg::KIND_DATA, 6'h00, 8'hFF);
        wait_drained();
        write_key_length(7'd127);
        send_item(rkx_pkg::KIND_DATA, 6'h00, 8'h00);

        lengths = '{7'd2, 7'd3, 7'd1, 7'd64, 7'd5, 7'd0, 7'd65, 7'd8,
                    7'd127, 7'd17, 7'd63, 7'($urandom_range(0, 127))};
        for (int ph = 0; ph < 12; ph++) begin
            steady = (ph == 4);
            run_phase(lengths[ph], (lengths[ph] < 4) ? 80 : 50,
                      (lengths[ph] < 4) ? 3 : 8, ph == 6);
        end
        steady = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("covered %0d key writes and %0d cipher bytes (%0d block ends)",
                 board.key_writes, board.data_bytes, board.block_ends);
        $display("across %0d key-length settings incl. 0, 1, 64 and above 64",
                 len_settings);
        if (board.errors == 0)
            $display("rotating_key_xor_cipher_tb: clean");
        else
            $display("rotating_key_xor_cipher_tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rkx_pkg.sv
hdl/rkx_front.sv
hdl/rkx_queue.sv
hdl/rkx_back.sv
hdl/rotating_key_xor_cipher.sv
dv/rotating_key_xor_cipher_tb.sv
